>>> rtl/eir_pkg.sv
// Package for the Earth rotation block: item types, fixed-point constants and elaboration helpers.
package eir_pkg;

  // Field widths of the transfer items.
  localparam int unsigned TIME_W = 40;
  localparam int unsigned POS_W  = 40;
  localparam int unsigned VEL_W  = 32;

  // Arithmetic formats.
  localparam int unsigned CORDIC_STEPS_DEFAULT = 24;
  localparam int unsigned TIME_FRAC_BITS       = 10;
  localparam int unsigned PHASE_BITS           = 44;
  localparam int unsigned RESID_W              = PHASE_BITS - 2;
  localparam int unsigned Q_BITS               = 60;
  localparam int unsigned ANGLE_SHIFT          = PHASE_BITS - 1;

  localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
  localparam logic [63:0] EARTH_RATE_Q60 = PI_Q60 / 64'd43200;

  // One solar day is 675 * 2^7 seconds, so only the odd factor needs a divider.
  localparam int unsigned DAY_ODD   = 675;
  localparam int unsigned DAY_SHIFT = 7;
  localparam int unsigned DIV_BITS  = 10;

  localparam int unsigned LOW_BITS   = DAY_SHIFT + TIME_FRAC_BITS;
  localparam int unsigned HIGH_W     = TIME_W - LOW_BITS;
  localparam int unsigned FRAC_SHIFT = PHASE_BITS - LOW_BITS;

  // Reciprocals for exact floor division by DAY_ODD.
  localparam int unsigned K_H  = HIGH_W + DIV_BITS;
  localparam int unsigned MH_W = K_H - (DIV_BITS - 1);
  localparam int unsigned QH_W = HIGH_W - (DIV_BITS - 1);
  localparam logic [63:0] M_H  = ((64'd1 << K_H) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD);

  localparam int unsigned X_W  = DIV_BITS + LOW_BITS;
  localparam int unsigned K_1  = X_W + DIV_BITS;
  localparam int unsigned M1_W = K_1 - (DIV_BITS - 1);
  localparam logic [63:0] M_1  = ((64'd1 << K_1) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD);

  localparam int unsigned K_2  = FRAC_SHIFT + 2 * DIV_BITS;
  localparam int unsigned M2_W = K_2 - (DIV_BITS - 1);
  localparam logic [63:0] M_2  = ((64'd1 << K_2) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD);

  // Saturation limits.
  localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
  localparam logic signed [63:0] POS_MIN = -POS_MAX - 64'sd1;
  localparam logic signed [63:0] VEL_MAX = (64'sd1 <<< (VEL_W - 1)) - 64'sd1;
  localparam logic signed [63:0] VEL_MIN = -VEL_MAX - 64'sd1;

  typedef struct packed {
    logic                     operation;
    logic [TIME_W-1:0]        time_ticks;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic signed [VEL_W-1:0]  vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  out_pos_x;
    logic signed [POS_W-1:0]  out_pos_y;
    logic signed [POS_W-1:0]  out_pos_z;
    logic signed [VEL_W-1:0]  out_vel_x;
    logic signed [VEL_W-1:0]  out_vel_y;
    logic signed [VEL_W-1:0]  out_vel_z;
  } res_item_t;

  // Phase unit to CORDIC: quadrant and residual angle in turns.
  typedef struct packed {
    logic                      valid;
    logic [1:0]                quad;
    logic signed [RESID_W-1:0] resid;
  } phase_out_t;

  // Arctangent of 2^-i in Q60 radians by its truncated series.
  function automatic logic signed [63:0] atan_q60(int unsigned i);
    logic signed [63:0] acc;
    logic [63:0]        t;
    int unsigned        k;
    acc = '0;
    for (k = 0; k < 32; k++) begin
      if (i * (2 * k + 1) <= Q_BITS) begin
        t = (64'd1 << (Q_BITS - i * (2 * k + 1))) / 64'(2 * k + 1);
        acc = k[0] ? acc - $signed(t) : acc + $signed(t);
      end
    end
    return acc;
  endfunction

  // 1/sqrt(1 + 2^-2i) in Q60 by its truncated binomial series.
  function automatic logic [63:0] inv_sqrt_q60(int unsigned i);
    logic [63:0] f;
    logic [63:0] t;
    logic        stop;
    int unsigned k;
    f = 64'd1 << Q_BITS;
    t = 64'd1 << Q_BITS;
    stop = 1'b0;
    for (k = 0; k < 64; k++) begin
      if (!stop) begin
        t = (2 * i < 64) ? (t >> (2 * i)) : 64'd0;
        t = t / 64'(2 * k + 2) * 64'(2 * k + 1);
        if (t == 64'd0) begin
          stop = 1'b1;
        end else if (k[0]) begin
          f = f + t;
        end else begin
          f = f - t;
        end
      end
    end
    return f;
  endfunction

  // Product of the per-step gains, each product rounded half up in Q60.
  function automatic logic [63:0] cordic_gain(int unsigned steps);
    logic [127:0] prod;
    logic [63:0]  g;
    int unsigned  i;
    g = 64'd1 << Q_BITS;
    for (i = 1; i <= steps; i++) begin
      prod = 128'(g) * 128'(inv_sqrt_q60(i)) + (128'd1 << (Q_BITS - 1));
      g = prod[Q_BITS+63:Q_BITS];
    end
    return g;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
    return r[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > VEL_MAX) ? VEL_MAX : ((v < VEL_MIN) ? VEL_MIN : v);
    return r[VEL_W-1:0];
  endfunction

endpackage

>>> rtl/eir_delay.sv
// Plain register line that keeps side data aligned with the arithmetic pipeline.
module eir_delay #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] line_q [Depth];

  // Shift the line by one place every cycle.
  always_ff @(posedge clk_i) begin
    line_q[0] <= d_i;
    for (int unsigned i = 1; i < Depth; i++) begin
      line_q[i] <= line_q[i-1];
    end
  end

  assign q_o = line_q[Depth-1];

endmodule

>>> rtl/eir_phase.sv
// Six-stage phase unit: time to turn fraction, direction, quadrant and residual.
module eir_phase import eir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              op_i,
  input  logic [TIME_W-1:0] ticks_i,
  output phase_out_t        out_o
);

  localparam logic [PHASE_BITS-1:0] HALF_QUAD = PHASE_BITS'(1) << (PHASE_BITS - 3);

  logic [5:0] vld_q;
  logic [5:0] op_q;

  logic [HIGH_W-1:0]      hi_q;
  logic [LOW_BITS-1:0]    lo_q;
  logic [HIGH_W+MH_W-1:0] prod_h_q;
  logic [X_W-1:0]         x2_q, x3_q;
  logic [X_W+M1_W-1:0]    prod1_q;
  logic [LOW_BITS-1:0]    q1_q, q1b_q;
  logic [DIV_BITS-1:0]    r1_q;
  logic [DIV_BITS+M2_W-1:0] prod2_q;
  logic [1:0]             quad_q;
  logic signed [RESID_W-1:0] resid_q;

  logic [QH_W-1:0]       qh;
  logic [HIGH_W-1:0]     hrem_full;
  logic [LOW_BITS-1:0]   q1;
  logic [X_W-1:0]        r1_full;
  logic [PHASE_BITS-1:0] phase, p;

  // Quotient and remainder of the whole days, then the day fraction.
  assign qh        = prod_h_q[K_H +: QH_W];
  assign hrem_full = hi_q - HIGH_W'(HIGH_W'(qh) * HIGH_W'(DAY_ODD));
  assign q1        = prod1_q[K_1 +: LOW_BITS];
  assign r1_full   = x3_q - X_W'(X_W'(q1) * X_W'(DAY_ODD));
  assign phase     = {q1b_q, prod2_q[2*DIV_BITS +: FRAC_SHIFT]};
  // The reverse direction negates the phase; both add the eighth-turn offset.
  assign p         = op_q[4] ? (HALF_QUAD - phase) : (phase + HALF_QUAD);

  // Valid and direction travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= {op_q[4:0], op_i};
    hi_q     <= ticks_i[TIME_W-1:LOW_BITS];
    lo_q     <= ticks_i[LOW_BITS-1:0];
    prod_h_q <= (HIGH_W+MH_W)'(ticks_i[TIME_W-1:LOW_BITS]) * (HIGH_W+MH_W)'(M_H[MH_W-1:0]);
    x2_q     <= {hrem_full[DIV_BITS-1:0], lo_q};
    x3_q     <= x2_q;
    prod1_q  <= (X_W+M1_W)'(x2_q) * (X_W+M1_W)'(M_1[M1_W-1:0]);
    q1_q     <= q1;
    r1_q     <= r1_full[DIV_BITS-1:0];
    q1b_q    <= q1_q;
    prod2_q  <= (DIV_BITS+M2_W)'(r1_q) * (DIV_BITS+M2_W)'(M_2[M2_W-1:0]);
    quad_q   <= p[PHASE_BITS-1:PHASE_BITS-2];
    resid_q  <= {~p[RESID_W-1], p[RESID_W-2:0]};
  end

  assign out_o.valid = vld_q[5];
  assign out_o.quad  = quad_q;
  assign out_o.resid = resid_q;

endmodule

>>> rtl/eir_smul.sv
// Five-stage signed multiply with magnitude rounding half up and a fixed right shift.
module eir_smul import eir_pkg::*; #(
  parameter int unsigned Shift = Q_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               valid_o,
  output logic signed [63:0] p_o
);

  localparam logic [127:0] ROUND = 128'd1 << (Shift - 1);

  logic [4:0]   vld_q;
  logic [3:0]   neg_q;
  logic [63:0]  ma_q, mb_q;
  logic [63:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [64:0]  mid_q;
  logic [127:0] outer_q;
  logic [63:0]  mag_q;
  logic signed [63:0] p_q;
  logic [127:0] full;

  assign full = outer_q + (128'(mid_q) << 32) + ROUND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Magnitudes, 32-bit partial products, their sum, then the sign.
  always_ff @(posedge clk_i) begin
    neg_q   <= {neg_q[2:0], a_i[63] ^ b_i[63]};
    ma_q    <= a_i[63] ? (~a_i + 64'd1) : a_i;
    mb_q    <= b_i[63] ? (~b_i + 64'd1) : b_i;
    pp00_q  <= 64'(ma_q[31:0])  * 64'(mb_q[31:0]);
    pp01_q  <= 64'(ma_q[31:0])  * 64'(mb_q[63:32]);
    pp10_q  <= 64'(ma_q[63:32]) * 64'(mb_q[31:0]);
    pp11_q  <= 64'(ma_q[63:32]) * 64'(mb_q[63:32]);
    mid_q   <= 65'(pp01_q) + 65'(pp10_q);
    outer_q <= {pp11_q, pp00_q};
    mag_q   <= full[Shift+63:Shift];
    p_q     <= neg_q[3] ? $signed(~mag_q + 64'd1) : $signed(mag_q);
  end

  assign valid_o = vld_q[4];
  assign p_o     = p_q;

endmodule

>>> rtl/eir_cordic.sv
// Rotation-mode CORDIC, one register stage per step, then the quadrant fold.
module eir_cordic import eir_pkg::*; #(
  parameter int unsigned Steps = CORDIC_STEPS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [63:0] z_i,
  input  logic [1:0]         quad_i,
  output logic               valid_o,
  output logic signed [63:0] cos_o,
  output logic signed [63:0] sin_o
);

  localparam logic signed [63:0] GAIN = $signed(cordic_gain(Steps));

  logic               vld_q  [Steps];
  logic [1:0]         quad_q [Steps];
  logic signed [63:0] x_q    [Steps];
  logic signed [63:0] y_q    [Steps];
  logic signed [63:0] z_q    [Steps];

  logic               out_vld_q;
  logic signed [63:0] cos_q, sin_q;
  logic signed [63:0] cos_d, sin_d;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic signed [63:0] Atan = atan_q60(i + 1);
    logic               vld_in;
    logic [1:0]         quad_in;
    logic signed [63:0] x_in, y_in, z_in;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign quad_in = quad_i;
      assign x_in    = GAIN;
      assign y_in    = '0;
      assign z_in    = z_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign quad_in = quad_q[i-1];
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    // Turn toward zero residual angle.
    always_ff @(posedge clk_i) begin
      quad_q[i] <= quad_in;
      if (!z_in[63]) begin
        x_q[i] <= x_in - (y_in >>> (i + 1));
        y_q[i] <= y_in + (x_in >>> (i + 1));
        z_q[i] <= z_in - Atan;
      end else begin
        x_q[i] <= x_in + (y_in >>> (i + 1));
        y_q[i] <= y_in - (x_in >>> (i + 1));
        z_q[i] <= z_in + Atan;
      end
    end
  end

  // Fold the quarter turns back into cosine and sine.
  always_comb begin
    unique case (quad_q[Steps-1])
      2'd1: begin
        cos_d = -y_q[Steps-1];
        sin_d = x_q[Steps-1];
      end
      2'd2: begin
        cos_d = -x_q[Steps-1];
        sin_d = -y_q[Steps-1];
      end
      2'd3: begin
        cos_d = y_q[Steps-1];
        sin_d = -x_q[Steps-1];
      end
      default: begin
        cos_d = x_q[Steps-1];
        sin_d = y_q[Steps-1];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
    sin_q <= sin_d;
  end

  assign valid_o = out_vld_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

>>> rtl/earth_fixed_inertial_rotation.sv
// Top level: Earth-fixed / inertial rotation of position and velocity about z.
//
// Fully pipelined: a new item is taken in every clock cycle, and each result
// appears on res_o with a one-cycle done_o strobe. The path runs through the
// phase reduction (6 stages), the angle scaling multiply (5), one CORDIC stage
// per step plus the quadrant fold, the rotation multipliers (5), the
// cross-product multipliers (5) and two adder stages. Results cannot be held
// off by the receiver; busy is high only during reset.
module earth_fixed_inertial_rotation import eir_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_i,
  output logic      done_o,
  output res_item_t res_o
);

  localparam int unsigned ROT_DELAY = CORDIC_STEPS + 12;
  localparam int unsigned END_DELAY = CORDIC_STEPS + 23;
  localparam int unsigned LATENCY   = CORDIC_STEPS + 24;
  localparam int unsigned SIDE_W    = 2 * POS_W + 2 * VEL_W;
  localparam int unsigned TAIL_W    = 1 + POS_W + VEL_W;

  logic               accept;
  phase_out_t         ph;
  logic [1:0]         quad_z;
  logic               z_vld;
  logic signed [63:0] z_angle;
  logic               cs_vld;
  logic signed [63:0] cos_w, sin_w;

  logic [SIDE_W-1:0]       side;
  logic signed [POS_W-1:0] px_d, py_d;
  logic signed [VEL_W-1:0] vx_d, vy_d;
  logic [TAIL_W-1:0]       tail;
  logic                    op_d;
  logic signed [POS_W-1:0] pz_d;
  logic signed [VEL_W-1:0] vz_d;

  logic signed [63:0] mul_a [8];
  logic signed [63:0] mul_b [8];
  logic signed [63:0] mul_p [8];
  logic [7:0]         mul_vld;

  logic               comb_vld_q;
  logic signed [63:0] rx_q, ry_q, wx_q, wy_q;
  logic [255:0]       comb_dly;
  logic signed [63:0] rx_d, ry_d, wx_d, wy_d;
  logic               cx_vld, cy_vld;
  logic signed [63:0] cx, cy;
  logic signed [63:0] vel_x_fin, vel_y_fin;

  logic      done_q;
  res_item_t res_q;

  assign accept = start & ~busy;
  assign busy   = ~rst_ni;

  // Turn fraction of the day and its quadrant split.
  eir_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .op_i    (in_i.operation),
    .ticks_i (in_i.time_ticks),
    .out_o   (ph)
  );

  // Residual turns to Q60 radians.
  eir_smul #(.Shift(ANGLE_SHIFT)) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph.valid),
    .a_i     (64'(ph.resid)),
    .b_i     ($signed(PI_Q60)),
    .valid_o (z_vld),
    .p_o     (z_angle)
  );

  eir_delay #(.Width(2), .Depth(5)) u_quad_dly (
    .clk_i (clk_i),
    .d_i   (ph.quad),
    .q_o   (quad_z)
  );

  eir_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (z_vld),
    .z_i     (z_angle),
    .quad_i  (quad_z),
    .valid_o (cs_vld),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  // Position and velocity wait for the sine and cosine.
  eir_delay #(.Width(SIDE_W), .Depth(ROT_DELAY)) u_side_dly (
    .clk_i (clk_i),
    .d_i   ({in_i.pos_x, in_i.pos_y, in_i.vel_x, in_i.vel_y}),
    .q_o   (side)
  );

  assign {px_d, py_d, vx_d, vy_d} = side;

  eir_delay #(.Width(TAIL_W), .Depth(END_DELAY)) u_tail_dly (
    .clk_i (clk_i),
    .d_i   ({in_i.operation, in_i.pos_z, in_i.vel_z}),
    .q_o   (tail)
  );

  assign {op_d, pz_d, vz_d} = tail;

  // Operand pairs of the eight rotation products.
  always_comb begin
    mul_a[0] = cos_w;  mul_b[0] = 64'(px_d);
    mul_a[1] = sin_w;  mul_b[1] = 64'(py_d);
    mul_a[2] = sin_w;  mul_b[2] = 64'(px_d);
    mul_a[3] = cos_w;  mul_b[3] = 64'(py_d);
    mul_a[4] = cos_w;  mul_b[4] = 64'(vx_d);
    mul_a[5] = sin_w;  mul_b[5] = 64'(vy_d);
    mul_a[6] = sin_w;  mul_b[6] = 64'(vx_d);
    mul_a[7] = cos_w;  mul_b[7] = 64'(vy_d);
  end

  for (genvar m = 0; m < 8; m++) begin : g_rot
    eir_smul #(.Shift(Q_BITS)) u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cs_vld),
      .a_i     (mul_a[m]),
      .b_i     (mul_b[m]),
      .valid_o (mul_vld[m]),
      .p_o     (mul_p[m])
    );
  end

  // Rotated position and velocity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comb_vld_q <= 1'b0;
    end else begin
      comb_vld_q <= &mul_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q <= mul_p[0] - mul_p[1];
    ry_q <= mul_p[2] + mul_p[3];
    wx_q <= mul_p[4] - mul_p[5];
    wy_q <= mul_p[6] + mul_p[7];
  end

  // Earth rate crossed with the rotated position.
  eir_smul #(.Shift(Q_BITS)) u_cross_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (comb_vld_q),
    .a_i     ($signed(EARTH_RATE_Q60)),
    .b_i     (rx_q),
    .valid_o (cx_vld),
    .p_o     (cx)
  );

  eir_smul #(.Shift(Q_BITS)) u_cross_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (comb_vld_q),
    .a_i     ($signed(EARTH_RATE_Q60)),
    .b_i     (ry_q),
    .valid_o (cy_vld),
    .p_o     (cy)
  );

  eir_delay #(.Width(256), .Depth(5)) u_comb_dly (
    .clk_i (clk_i),
    .d_i   ({rx_q, ry_q, wx_q, wy_q}),
    .q_o   (comb_dly)
  );

  assign {rx_d, ry_d, wx_d, wy_d} = comb_dly;

  // Velocity correction, sign set by the direction.
  assign vel_x_fin = op_d ? (wx_d + cy) : (wx_d - cy);
  assign vel_y_fin = op_d ? (wy_d - cx) : (wy_d + cx);

  // Saturated output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cx_vld & cy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.out_pos_x <= sat_pos(rx_d);
    res_q.out_pos_y <= sat_pos(ry_d);
    res_q.out_pos_z <= pz_d;
    res_q.out_vel_x <= sat_vel(vel_x_fin);
    res_q.out_vel_y <= sat_vel(vel_y_fin);
    res_q.out_vel_z <= vz_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A result only follows a transfer taken the full latency earlier.
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY) && $past(rst_ni, LATENCY))
    else $error("result strobe without a matching start transfer");

  // The pass-through fields stay aligned with their own item.
  a_z_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.out_pos_z == $past(in_i.pos_z, LATENCY)) &&
               (res_o.out_vel_z == $past(in_i.vel_z, LATENCY)))
    else $error("pass-through fields out of step with the result");

  // Sine and cosine arrive together with the delayed position and velocity.
  a_trig_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_vld |-> $past(start, ROT_DELAY) && (px_d == $past(in_i.pos_x, ROT_DELAY)))
    else $error("rotation operands misaligned");

endmodule
